[hdl/tcfl_pkg.sv]
`default_nettype none
package tcfl_pkg;

   // Convergence order of the scheme and the divisor that follows from it.
   localparam int ORDER    = 6;
   localparam int RATE_DIV = 2 * ORDER - 1;

   // Configuration register indexes.
   localparam logic [0:0] CSR_COURANT = 1'b0;
   localparam logic [0:0] CSR_CAP     = 1'b1;

   localparam logic [17:0] COURANT_RESET = 18'd32768;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } vert_type;

   // One complete cell as handed from the front end to the arithmetic back end.
   typedef struct packed {
      vert_type [3:0] vert;
      logic [23:0]    wave_speed;
      logic           clear_ext;
   } job_type;

endpackage
`default_nettype wire

[hdl/tcfl_chan_if.sv]
`default_nettype none
interface tcfl_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic signed [31:0] coord_z;
   logic [23:0]        wave_speed;
   logic               restart;

   modport source (output valid, coord_x, coord_y, coord_z, wave_speed, restart,
                   input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, wave_speed, restart,
                 output ready);
endinterface

interface tcfl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] cell_step;
   logic [31:0] least_step;
   logic [31:0] greatest_step;
   logic        degenerate;

   modport source (output valid, cell_step, least_step, greatest_step, degenerate,
                   input ready);
   modport sink (input valid, cell_step, least_step, greatest_step, degenerate,
                 output ready);
endinterface
`default_nettype wire

[hdl/tcfl_front.sv]
`default_nettype none
module tcfl_front (
   input wire logic           clock,
   input wire logic           reset,
   tcfl_req_if.sink           req_ch,
   input wire logic           queue_full,
   output logic               push,
   output tcfl_pkg::job_type  push_job
);

   logic [1:0]         count_ff, count_in;
   logic               sticky_ff, sticky_in;
   tcfl_pkg::vert_type held_ff [3];
   tcfl_pkg::vert_type cur_vert;
   logic               accept;
   logic [1:0]         slot;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   // A restart makes this request vertex 0 of a new cell.
   assign slot         = req_ch.restart ? 2'd0 : count_ff;

   assign cur_vert.x = req_ch.coord_x;
   assign cur_vert.y = req_ch.coord_y;
   assign cur_vert.z = req_ch.coord_z;

   always_comb begin
      count_in  = count_ff;
      sticky_in = sticky_ff;
      push      = 1'b0;
      if (accept) begin
         if (slot == 2'd3) begin
            push      = 1'b1;
            count_in  = 2'd0;
            sticky_in = 1'b0;
         end else begin
            count_in  = slot + 2'd1;
            sticky_in = sticky_ff | req_ch.restart;
         end
      end
   end

   assign push_job.vert[0]    = held_ff[0];
   assign push_job.vert[1]    = held_ff[1];
   assign push_job.vert[2]    = held_ff[2];
   assign push_job.vert[3]    = cur_vert;
   assign push_job.wave_speed = req_ch.wave_speed;
   assign push_job.clear_ext  = sticky_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         sticky_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && slot != 2'd3) begin
         held_ff[slot] <= cur_vert;
      end
   end

endmodule
`default_nettype wire

[hdl/tcfl_queue.sv]
`default_nettype none
module tcfl_queue (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              push,
   input wire tcfl_pkg::job_type push_job,
   output logic                  full,
   output logic                  nonempty,
   input wire logic              pop,
   output tcfl_pkg::job_type     pop_job
);

   tcfl_pkg::job_type                  entry_ff [tcfl_pkg::QUEUE_DEPTH];
   logic [tcfl_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [tcfl_pkg::QUEUE_CNT_W-1:0]   fill_ff, fill_in;

   assign full     = (fill_ff == tcfl_pkg::QUEUE_CNT_W'(tcfl_pkg::QUEUE_DEPTH));
   assign nonempty = (fill_ff != '0);
   assign pop_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

[hdl/tcfl_back.sv]
`default_nettype none
module tcfl_back (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              job_valid,
   input wire tcfl_pkg::job_type job,
   output logic                  pop,
   input wire logic [17:0]       courant_factor,
   input wire logic [31:0]       step_cap,
   tcfl_rsp_if.source            rsp_ch
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_ISSUE   = 9'b000000010,
      ST_MUL     = 9'b000000100,
      ST_POST    = 9'b000001000,
      ST_SQRT    = 9'b000010000,
      ST_NORM    = 9'b000100000,
      ST_DIVINIT = 9'b001000000,
      ST_DIV     = 9'b010000000,
      ST_FIN     = 9'b100000000
   } state_type;

   // Which product the shared multiplier is working on.
   typedef enum logic [6:0] {
      OP_CR1  = 7'b0000001,
      OP_CR2  = 7'b0000010,
      OP_SQ   = 7'b0000100,
      OP_DET  = 7'b0001000,
      OP_NUM  = 7'b0010000,
      OP_DEN1 = 7'b0100000,
      OP_DEN2 = 7'b1000000
   } op_type;

   typedef struct packed {
      logic [32:0] x;
      logic [32:0] y;
      logic [32:0] z;
   } edge_type;

   function automatic edge_type diff(input tcfl_pkg::vert_type p, input tcfl_pkg::vert_type q);
      edge_type d;
      d.x = {p.x[31], p.x} - {q.x[31], q.x};
      d.y = {p.y[31], p.y} - {q.y[31], q.y};
      d.z = {p.z[31], p.z} - {q.z[31], q.z};
      return d;
   endfunction

   function automatic logic [32:0] pick(input edge_type e, input logic [1:0] idx);
      logic [32:0] r;
      unique case (idx)
         2'd1:    r = e.y;
         2'd2:    r = e.z;
         default: r = e.x;
      endcase
      return r;
   endfunction

   function automatic logic [32:0] mag33(input logic [32:0] v);
      return v[32] ? (33'd0 - v) : v;
   endfunction

   function automatic logic [66:0] mag67(input logic [66:0] v);
      return v[66] ? (67'd0 - v) : v;
   endfunction

   function automatic logic [100:0] mag101(input logic [100:0] v);
      return v[100] ? (101'd0 - v) : v;
   endfunction

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   logic [1:0]    k_ff, k_in, j_ff, j_in;
   logic [6:0]    cnt_ff, cnt_in;

   edge_type      ea_ff, eb_ff, ec_ff, ee_ff, ef_ff;
   logic [23:0]   speed_ff;
   logic          clear_ff;

   logic [66:0]   comp_ff, comp_in;
   logic [66:0]   cbc_ff [3];
   logic          cbc_we;
   logic [131:0]  sumsq_ff, sumsq_in;
   logic [65:0]   root_ff, root_in;
   logic [66:0]   rem_ff, rem_in;
   logic [67:0]   s_ff, s_in;
   logic [100:0]  det_ff, det_in;
   logic [116:0]  num_ff, num_in;
   logic [95:0]   den_ff, den_in;

   logic [175:0]  mp_ff, mp_in;
   logic [71:0]   ma_ff, ma_in;
   logic [103:0]  mb_ff, mb_in;
   logic          mneg_ff, mneg_in;

   logic [127:0]  drem_ff, drem_in;
   logic [126:0]  dvs_ff, dvs_in;
   logic [31:0]   quo_ff, quo_in;
   logic          sat_ff, sat_in;
   logic          deg_ff, deg_in;

   logic          out_valid_ff, out_valid_in;
   logic [31:0]   out_step_ff, out_step_in;
   logic          out_deg_ff, out_deg_in;
   logic [31:0]   least_ff, least_in, greatest_ff, greatest_in;

   // Operand selection for the cross products.
   edge_type      u_vec, v_vec;
   logic [1:0]    j1, j2;
   logic [32:0]   uj1, uj2, vj1, vj2, aj;
   logic [71:0]   opa;
   logic [103:0]  opb;
   logic          opneg;

   logic [79:0]   mul_sum;
   logic [66:0]   comp_new;
   logic [68:0]   sq_rem2;
   logic [67:0]   sq_trial;
   logic          sq_ge;
   logic [125:0]  num_full;
   logic          div_ge;
   logic [31:0]   step_val, least_base, greatest_base;

   always_comb begin
      unique case (k_ff)
         2'd0:    begin u_vec = ea_ff; v_vec = eb_ff; end
         2'd1:    begin u_vec = ea_ff; v_vec = ec_ff; end
         2'd2:    begin u_vec = eb_ff; v_vec = ec_ff; end
         default: begin u_vec = ee_ff; v_vec = ef_ff; end
      endcase
      unique case (j_ff)
         2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
         2'd2:    begin j1 = 2'd0; j2 = 2'd1; end
         default: begin j1 = 2'd1; j2 = 2'd2; end
      endcase
   end

   assign uj1 = pick(u_vec, j1);
   assign uj2 = pick(u_vec, j2);
   assign vj1 = pick(v_vec, j1);
   assign vj2 = pick(v_vec, j2);
   assign aj  = pick(ea_ff, j_ff);

   always_comb begin
      opa   = '0;
      opb   = '0;
      opneg = 1'b0;
      unique case (op_ff)
         OP_CR1: begin
            opa   = 72'(mag33(uj1));
            opb   = 104'(mag33(vj2));
            opneg = uj1[32] ^ vj2[32];
         end
         OP_CR2: begin
            opa   = 72'(mag33(uj2));
            opb   = 104'(mag33(vj1));
            opneg = uj2[32] ^ vj1[32];
         end
         OP_SQ: begin
            opa = 72'(mag67(comp_ff));
            opb = 104'(mag67(comp_ff));
         end
         OP_DET: begin
            opa   = 72'(mag67(cbc_ff[j_ff]));
            opb   = 104'(mag33(aj));
            opneg = cbc_ff[j_ff][66] ^ aj[32];
         end
         OP_NUM: begin
            opa = 72'(courant_factor);
            opb = 104'(mag101(det_ff));
         end
         OP_DEN1: begin
            opa = 72'(s_ff);
            opb = 104'(speed_ff);
         end
         OP_DEN2: begin
            opa = 72'(tcfl_pkg::RATE_DIV);
            opb = 104'(den_ff);
         end
         default: begin
            opa = '0;
         end
      endcase
   end

   // One 8-bit digit of the second operand per cycle; the product shifts down.
   assign mul_sum  = {8'd0, mp_ff[175:104]} + (80'(ma_ff) * 80'(mb_ff[7:0]));
   assign comp_new = mneg_ff ? (comp_ff + mp_ff[66:0]) : (comp_ff - mp_ff[66:0]);

   assign sq_rem2  = {rem_ff, sumsq_ff[131:130]};
   assign sq_trial = {root_ff, 2'b01};
   assign sq_ge    = (sq_rem2 >= {1'b0, sq_trial});

   assign num_full = {num_ff, 9'd0};
   assign div_ge   = (drem_ff >= {1'b0, dvs_ff});

   assign step_val      = (sat_ff || quo_ff >= step_cap) ? step_cap : quo_ff;
   assign least_base    = clear_ff ? '1 : least_ff;
   assign greatest_base = clear_ff ? '0 : greatest_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      cbc_we       = 1'b0;
      sumsq_in     = sumsq_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      s_in         = s_ff;
      det_in       = det_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      mp_in        = mp_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mneg_in      = mneg_ff;
      drem_in      = drem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      sat_in       = sat_ff;
      deg_in       = deg_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_step_in  = out_step_ff;
      out_deg_in   = out_deg_ff;
      least_in     = least_ff;
      greatest_in  = greatest_ff;
      pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               k_in     = 2'd0;
               j_in     = 2'd0;
               op_in    = OP_CR1;
               s_in     = '0;
               det_in   = '0;
               sumsq_in = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            mp_in    = '0;
            ma_in    = opa;
            mb_in    = opb;
            mneg_in  = opneg;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mp_in = {mul_sum, mp_ff[103:8]};
            mb_in = mb_ff >> 8;
            if (cnt_ff == 7'd12) begin
               state_in = ST_POST;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_POST: begin
            state_in = ST_ISSUE;
            unique case (op_ff)
               OP_CR1: begin
                  comp_in = mneg_ff ? (67'd0 - mp_ff[66:0]) : mp_ff[66:0];
                  op_in   = OP_CR2;
               end
               OP_CR2: begin
                  comp_in = comp_new;
                  cbc_we  = (k_ff == 2'd2);
                  op_in   = OP_SQ;
               end
               OP_SQ: begin
                  sumsq_in = sumsq_ff + mp_ff[131:0];
                  if (j_ff == 2'd2) begin
                     root_in  = '0;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_SQRT;
                  end else begin
                     j_in  = j_ff + 2'd1;
                     op_in = OP_CR1;
                  end
               end
               OP_DET: begin
                  det_in = mneg_ff ? (det_ff - mp_ff[100:0]) : (det_ff + mp_ff[100:0]);
                  if (j_ff == 2'd2) begin
                     j_in  = 2'd0;
                     op_in = OP_NUM;
                  end else begin
                     j_in = j_ff + 2'd1;
                  end
               end
               OP_NUM: begin
                  num_in = mp_ff[116:0];
                  op_in  = OP_DEN1;
               end
               OP_DEN1: begin
                  den_in = mp_ff[95:0];
                  op_in  = OP_DEN2;
               end
               OP_DEN2: begin
                  den_in   = mp_ff[95:0];
                  state_in = ST_DIVINIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SQRT: begin
            rem_in   = sq_ge ? 67'(sq_rem2 - {1'b0, sq_trial}) : sq_rem2[66:0];
            root_in  = {root_ff[64:0], sq_ge};
            sumsq_in = sumsq_ff << 2;
            if (cnt_ff == 7'd65) begin
               state_in = ST_NORM;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_NORM: begin
            s_in     = s_ff + 68'(root_ff);
            j_in     = 2'd0;
            state_in = ST_ISSUE;
            if (k_ff == 2'd3) begin
               op_in = OP_DET;
            end else begin
               k_in  = k_ff + 2'd1;
               op_in = OP_CR1;
            end
         end
         ST_DIVINIT: begin
            deg_in  = (s_ff == '0) || (speed_ff == '0);
            // A quotient of 2^32 or more always saturates to the cap.
            sat_in  = (s_ff == '0) || (speed_ff == '0) ||
                      ({2'd0, num_full} >= {den_ff, 32'd0});
            drem_in = {2'd0, num_full};
            dvs_in  = {den_ff, 31'd0};
            quo_in  = '0;
            cnt_in  = '0;
            if ((s_ff == '0) || (speed_ff == '0) ||
                ({2'd0, num_full} >= {den_ff, 32'd0})) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            drem_in = div_ge ? (drem_ff - {1'b0, dvs_ff}) : drem_ff;
            quo_in  = {quo_ff[30:0], div_ge};
            dvs_in  = dvs_ff >> 1;
            if (cnt_ff == 7'd31) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_step_in  = step_val;
               out_deg_in   = deg_ff;
               least_in     = (step_val < least_base) ? step_val : least_base;
               greatest_in  = (step_val > greatest_base) ? step_val : greatest_base;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_CR1;
         k_ff         <= 2'd0;
         j_ff         <= 2'd0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         least_ff     <= '1;
         greatest_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         least_ff     <= least_in;
         greatest_ff  <= greatest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ea_ff    <= diff(job.vert[1], job.vert[0]);
         eb_ff    <= diff(job.vert[2], job.vert[0]);
         ec_ff    <= diff(job.vert[3], job.vert[0]);
         ee_ff    <= diff(job.vert[2], job.vert[1]);
         ef_ff    <= diff(job.vert[3], job.vert[1]);
         speed_ff <= job.wave_speed;
         clear_ff <= job.clear_ext;
      end
      if (cbc_we) begin
         cbc_ff[j_ff] <= comp_new;
      end
      comp_ff     <= comp_in;
      sumsq_ff    <= sumsq_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      s_ff        <= s_in;
      det_ff      <= det_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      mp_ff       <= mp_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      mneg_ff     <= mneg_in;
      drem_ff     <= drem_in;
      dvs_ff      <= dvs_in;
      quo_ff      <= quo_in;
      sat_ff      <= sat_in;
      deg_ff      <= deg_in;
      out_step_ff <= out_step_in;
      out_deg_ff  <= out_deg_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.cell_step     = out_step_ff;
   assign rsp_ch.least_step    = least_ff;
   assign rsp_ch.greatest_step = greatest_ff;
   assign rsp_ch.degenerate    = out_deg_ff;

endmodule
`default_nettype wire

[hdl/tetra_cfl_timestep_core.sv]
// Tetrahedral cell time step. Vertices arrive one request at a time; a restart
// request starts a new cell, and the fourth vertex of a cell closes it and produces
// one response with the cell step, the running minimum and maximum, and a
// degenerate flag. The front end takes vertex requests at one per cycle while a
// two-cell queue has room. For each cell the back end runs 42 products on a shared
// multiplier that consumes eight bits of one operand per cycle, four 66-step
// square roots, and a 32-step divider that is skipped when the result saturates
// to the cap. The response is held in an output register, so the back end can
// start the next cell's work while a finished response waits. Configuration
// registers may only be written while no cell is in flight.
`default_nettype none
module tetra_cfl_timestep_core (
   input wire logic        clock,
   input wire logic        reset,
   tcfl_req_if.sink        req_ch,
   tcfl_rsp_if.source      rsp_ch,
   input wire logic        csr_write_en,
   input wire logic [0:0]  csr_index,
   input wire logic [31:0] csr_wdata
);

   logic [17:0]       courant_ff;
   logic [31:0]       cap_ff;
   logic              push, queue_full, queue_nonempty, pop;
   tcfl_pkg::job_type push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         courant_ff <= tcfl_pkg::COURANT_RESET;
         cap_ff     <= '1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tcfl_pkg::CSR_COURANT: courant_ff <= csr_wdata[17:0];
            tcfl_pkg::CSR_CAP:     cap_ff     <= csr_wdata;
         endcase
      end
   end

   tcfl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   tcfl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .nonempty (queue_nonempty),
      .pop      (pop),
      .pop_job  (pop_job)
   );

   tcfl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (queue_nonempty),
      .job            (pop_job),
      .pop            (pop),
      .courant_factor (courant_ff),
      .step_cap       (cap_ff),
      .rsp_ch         (rsp_ch)
   );

endmodule
`default_nettype wire

[test/tetra_cfl_timestep_core_test.sv]
`default_nettype none
module tetra_cfl_timestep_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 1500000;
   localparam int DRAIN_CYCLES   = 1200;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int TABLE_ROWS     = 22;

   typedef logic signed [191:0] wide_s_type;
   typedef logic [191:0]        wide_u_type;

   typedef struct {
      logic [31:0] cell_step;
      logic [31:0] least_step;
      logic [31:0] greatest_step;
      logic        degenerate;
   } step_result_type;

   typedef struct {
      logic [31:0]     x;
      logic [31:0]     y;
      logic [31:0]     z;
      logic [23:0]     speed;
      logic            restart;
      bit              typed;
      step_result_type typed_result;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [0:0]  csr_index = tcfl_pkg::CSR_COURANT;
   logic [31:0] csr_wdata = '0;

   tcfl_req_if req_bus();
   tcfl_rsp_if rsp_bus();

   tetra_cfl_timestep_core dut (
      .clock(clock), .reset(reset),
      .req_ch(req_bus), .rsp_ch(rsp_bus),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow state of the block.
   logic [31:0] held_x [3];
   logic [31:0] held_y [3];
   logic [31:0] held_z [3];
   int          corner_count;
   logic [31:0] lowest_step, highest_step;
   logic [17:0] courant;
   logic [31:0] cap;

   step_result_type pending_steps[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  quiet_phase = 1'b0;
   table_row_type stim_table [TABLE_ROWS];
   int  table_fill = 0;

   function automatic wide_u_type root_floor(wide_u_type n);
      wide_u_type res, cand;
      res = '0;
      for (int k = 72; k >= 0; k--) begin
         cand = res | (wide_u_type'(1) << k);
         if (cand * cand <= n) res = cand;
      end
      return res;
   endfunction

   function automatic void cross_of(input wide_s_type u [3], input wide_s_type v [3],
                                    output wide_s_type c [3]);
      c[0] = u[1] * v[2] - u[2] * v[1];
      c[1] = u[2] * v[0] - u[0] * v[2];
      c[2] = u[0] * v[1] - u[1] * v[0];
   endfunction

   function automatic wide_u_type face_norm(input wide_s_type c [3]);
      return root_floor(wide_u_type'(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]));
   endfunction

   // Advances the shadow state by one vertex; returns 1 when a cell closes.
   function automatic bit step_of_cell(input logic [31:0] x, y, z, input logic [23:0] speed,
                                       input logic restart, output step_result_type r);
      wide_s_type p [4][3];
      wide_s_type ea [3], eb [3], ec [3], ee [3], ef [3];
      wide_s_type cab [3], cac [3], cbc [3], cef [3];
      wide_s_type det_s;
      wide_u_type face_sum, det, num, den, quo;
      logic [31:0] step;
      bit deg;
      if (restart) begin
         lowest_step = '1;
         highest_step = '0;
         corner_count = 0;
      end
      if (corner_count < 3) begin
         held_x[corner_count] = x;
         held_y[corner_count] = y;
         held_z[corner_count] = z;
         corner_count++;
         return 1'b0;
      end
      corner_count = 0;
      for (int i = 0; i < 3; i++) begin
         p[i][0] = wide_s_type'($signed(held_x[i]));
         p[i][1] = wide_s_type'($signed(held_y[i]));
         p[i][2] = wide_s_type'($signed(held_z[i]));
      end
      p[3][0] = wide_s_type'($signed(x));
      p[3][1] = wide_s_type'($signed(y));
      p[3][2] = wide_s_type'($signed(z));
      for (int i = 0; i < 3; i++) begin
         ea[i] = p[1][i] - p[0][i];
         eb[i] = p[2][i] - p[0][i];
         ec[i] = p[3][i] - p[0][i];
         ee[i] = p[2][i] - p[1][i];
         ef[i] = p[3][i] - p[1][i];
      end
      cross_of(ea, eb, cab);
      cross_of(ea, ec, cac);
      cross_of(eb, ec, cbc);
      cross_of(ee, ef, cef);
      face_sum = face_norm(cab) + face_norm(cac) + face_norm(cbc) + face_norm(cef);
      det_s = ea[0] * cbc[0] + ea[1] * cbc[1] + ea[2] * cbc[2];
      det = wide_u_type'(det_s < 0 ? -det_s : det_s);
      deg = 1'b0;
      step = cap;
      if (face_sum == 0 || speed == 0) begin
         deg = 1'b1;
      end else begin
         num = wide_u_type'(courant) * det * 512;
         den = face_sum * wide_u_type'(speed) * tcfl_pkg::RATE_DIV;
         quo = num / den;
         if (quo < wide_u_type'(cap)) step = quo[31:0];
      end
      if (step < lowest_step) lowest_step = step;
      if (step > highest_step) highest_step = step;
      r.cell_step = step;
      r.least_step = lowest_step;
      r.greatest_step = highest_step;
      r.degenerate = deg;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got, want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic add_row(input logic [31:0] x, y, z, input logic [23:0] speed,
                          input logic restart, input bit typed,
                          input logic [31:0] st = 0, lo = 0, hi = 0, input logic deg = 0);
      table_row_type row;
      row.x = x; row.y = y; row.z = z; row.speed = speed; row.restart = restart;
      row.typed = typed;
      row.typed_result = '{st, lo, hi, deg};
      stim_table[table_fill++] = row;
   endtask

   // Drives one request, waits for its acceptance and records what it should produce.
   task automatic send_vertex(input logic [31:0] x, y, z, input logic [23:0] speed,
                              input logic restart, input bit typed = 0,
                              input step_result_type typed_result = '{0, 0, 0, 0});
      step_result_type r;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.coord_x = x;
      req_bus.coord_y = y;
      req_bus.coord_z = z;
      req_bus.wave_speed = speed;
      req_bus.restart = restart;
      do @(posedge clock); while (!req_bus.ready);
      if (step_of_cell(x, y, z, speed, restart, r))
         pending_steps.push_back(typed ? typed_result : r);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [31:0] value);
      csr_write_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      if (index == tcfl_pkg::CSR_COURANT) courant = value[17:0];
      else cap = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic settle;
      wait (pending_steps.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] random_coord(int scale);
      logic [31:0] raw;
      raw = $urandom;
      if (scale >= 31) return raw;
      return $signed(raw) >>> (31 - scale);
   endfunction

   task automatic send_random_cell;
      logic [31:0] bx, by, bz, vx, vy, vz;
      logic [23:0] speed;
      int scale, shape;
      scale = $urandom_range(4, 31);
      shape = $urandom_range(0, 9);
      bx = $urandom; by = $urandom; bz = $urandom;
      if (scale < 31) begin
         bx = random_coord(scale + 1);
         by = random_coord(scale + 1);
         bz = random_coord(scale + 1);
      end
      case ($urandom_range(0, 9))
         0: speed = '0;
         1, 2: speed = 24'($urandom_range(1, 255));
         default: speed = 24'($urandom);
      endcase
      for (int v = 0; v < 4; v++) begin
         vx = bx + random_coord(scale);
         vy = by + random_coord(scale);
         vz = bz + random_coord(scale);
         // Repeated or all-equal corners make flat and degenerate cells.
         if (shape == 0 || (shape == 1 && v == 3)) begin
            vx = bx; vy = by; vz = bz;
         end
         send_vertex(vx, vy, vz, speed, $urandom_range(0, 39) == 0);
      end
      // A stray vertex now and then breaks the cell framing.
      if ($urandom_range(0, 19) == 0)
         send_vertex($urandom, $urandom, $urandom, 24'($urandom),
                     1'($urandom_range(0, 1)));
   endtask

   always @(negedge clock) begin
      static int stall = 0;
      if (stall > 0) begin
         stall--;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         stall = $urandom_range(0, 5);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_steps.size() == 0) begin
            $display("unexpected response at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = pending_steps.pop_front();
            if (rsp_bus.cell_step !== want.cell_step)
               report_mismatch("cell_step", rsp_bus.cell_step, want.cell_step);
            if (rsp_bus.least_step !== want.least_step)
               report_mismatch("least_step", rsp_bus.least_step, want.least_step);
            if (rsp_bus.greatest_step !== want.greatest_step)
               report_mismatch("greatest_step", rsp_bus.greatest_step, want.greatest_step);
            if (rsp_bus.degenerate !== want.degenerate)
               report_mismatch("degenerate", rsp_bus.degenerate, want.degenerate);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [31:0] lo, hi;
      req_bus.valid = 1'b0;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      req_bus.coord_z = '0;
      req_bus.wave_speed = '0;
      req_bus.restart = 1'b0;
      rsp_bus.ready = 1'b0;
      corner_count = 0;
      lowest_step = '1;
      highest_step = '0;
      courant = tcfl_pkg::COURANT_RESET;
      cap = '1;
      lo = 32'h8000_0000;
      hi = 32'h7fff_ffff;

      // All corners equal: no faces, so the cap comes back flagged.
      add_row(0, 0, 0, 100, 1, 0);
      add_row(0, 0, 0, 100, 0, 0);
      add_row(0, 0, 0, 100, 0, 0);
      add_row(0, 0, 0, 100, 0, 1, '1, '1, '1, 1);
      // Flat cell with real faces gives a zero step.
      add_row(0, 0, 0, 100, 0, 0);
      add_row(256, 0, 0, 100, 0, 0);
      add_row(0, 256, 0, 100, 0, 0);
      add_row(512, 512, 0, 100, 0, 1, 0, 0, '1, 0);
      // Proper cell with zero speed.
      add_row(0, 0, 0, 0, 0, 0);
      add_row(256, 0, 0, 0, 0, 0);
      add_row(0, 256, 0, 0, 0, 0);
      add_row(0, 0, 256, 0, 0, 1, '1, 0, '1, 1);
      // Coordinate extremes with the slowest speed saturate the quotient.
      add_row(lo, lo, lo, 1, 0, 0);
      add_row(hi, lo, lo, 1, 0, 0);
      add_row(lo, hi, lo, 1, 0, 0);
      add_row(lo, lo, hi, 1, 0, 0);
      // Partial cell cut short by a restart, then an ordinary cell at top speed.
      add_row(1000, 2000, 3000, 5, 0, 0);
      add_row(4000, 5000, 6000, 5, 0, 0);
      add_row(-2560, 1280, 640, 24'hffffff, 1, 0);
      add_row(2560, 0, 0, 24'hffffff, 0, 0);
      add_row(0, 2560, 7, 24'hffffff, 0, 0);
      add_row(-5, 3, 2560, 24'hffffff, 0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < TABLE_ROWS; i++)
         send_vertex(stim_table[i].x, stim_table[i].y, stim_table[i].z, stim_table[i].speed,
                     stim_table[i].restart, stim_table[i].typed, stim_table[i].typed_result);

      for (int phase = 0; phase < 4; phase++) begin
         int sent;
         settle();
         case (phase)
            0: begin
               write_csr(tcfl_pkg::CSR_COURANT, 0);
               write_csr(tcfl_pkg::CSR_CAP, '1);
            end
            1: begin
               write_csr(tcfl_pkg::CSR_COURANT, 18'h3ffff);
               write_csr(tcfl_pkg::CSR_CAP, 0);
            end
            2: begin
               write_csr(tcfl_pkg::CSR_COURANT, $urandom_range(1, 18'h3ffff));
               write_csr(tcfl_pkg::CSR_CAP, $urandom);
            end
            default: begin
               write_csr(tcfl_pkg::CSR_COURANT, 18'h3ffff);
               write_csr(tcfl_pkg::CSR_CAP, '1);
               quiet_phase = 1'b1;
            end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            send_random_cell();
            sent += 4;
         end
         // Finish any open cell so the next register write lands between cells.
         while (corner_count != 0)
            send_vertex($urandom, $urandom, $urandom, 24'($urandom), 1'b0);
      end

      settle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
